>>> hdl/mcdr_pkg.sv
// Shared types and constants for the multi-channel debounce reporter.
`default_nettype none
package mcdr_pkg;
	localparam int unsigned CHANNELS_DEF = 12;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned TICKS_W = 16;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned BYTE_W = 8;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	localparam cfg_index_t REG_ACTIVE_LOW_MASK = 2'd0;
	localparam cfg_index_t REG_DEBOUNCE_TICKS = 2'd1;
	localparam cfg_index_t REG_HEARTBEAT_TICKS = 2'd2;

	localparam logic [TICKS_W-1:0] DEBOUNCE_TICKS_RST = 16'd25;
	localparam logic [TICKS_W-1:0] HEARTBEAT_TICKS_RST = 16'd1000;
	localparam logic [BYTE_W-1:0] STATUS_BYTE = 8'h3F;

	typedef enum logic [KIND_W-1:0] {
		KIND_EVENT = 2'd0,
		KIND_HEARTBEAT = 2'd1,
		KIND_STATUS = 2'd2
	} report_kind_t;

	typedef struct packed {
		logic load;
		logic init;
	} deb_ctl_t;
endpackage
`default_nettype wire

>>> hdl/mcdr_if.sv
// Tick request and report channel interfaces.
`default_nettype none
interface mcdr_tick_if #(
	parameter int unsigned CHANNELS = mcdr_pkg::CHANNELS_DEF
);
	logic valid;
	logic ready;
	logic [CHANNELS-1:0] raw_pins;
	logic rx_valid;
	logic [mcdr_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, raw_pins, rx_valid, rx_byte, input ready);
	modport sink (input valid, raw_pins, rx_valid, rx_byte, output ready);
endinterface

interface mcdr_report_if #(
	parameter int unsigned CHANNELS = mcdr_pkg::CHANNELS_DEF
);
	logic valid;
	logic ready;
	logic [mcdr_pkg::KIND_W-1:0] report_kind;
	logic [CHANNELS-1:0] stable_vector;
	logic [mcdr_pkg::TIME_W-1:0] timestamp;
	logic any_pressed;
	logic last;

	modport source (output valid, report_kind, stable_vector, timestamp, any_pressed, last,
		input ready);
	modport sink (input valid, report_kind, stable_vector, timestamp, any_pressed, last,
		output ready);
endinterface
`default_nettype wire

>>> hdl/mcdr_debounce.sv
// Per-channel debounce lanes: last level, stable level and change time.
`default_nettype none
module mcdr_debounce #(
	parameter int unsigned CHANNELS = mcdr_pkg::CHANNELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mcdr_pkg::deb_ctl_t            ctl,
	input  wire logic [CHANNELS-1:0]           pressed,
	input  wire logic [mcdr_pkg::TIME_W-1:0]   now,
	input  wire logic [mcdr_pkg::TICKS_W-1:0]  debounce_ticks,
	output logic [CHANNELS-1:0]                stable_next,
	output logic                               changed
);
	logic [CHANNELS-1:0] prev_q;
	logic [CHANNELS-1:0] stable_q;
	logic [mcdr_pkg::TIME_W-1:0] ct_q [CHANNELS];
	logic [mcdr_pkg::TIME_W-1:0] ct_next [CHANNELS];
	logic [mcdr_pkg::TIME_W-1:0] elapsed;

	always_comb begin
		elapsed = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			ct_next[i] = (ctl.init || (pressed[i] != prev_q[i])) ? now : ct_q[i];
			elapsed = now - ct_next[i];
			stable_next[i] = (ctl.init
				|| (elapsed >= {{(mcdr_pkg::TIME_W-mcdr_pkg::TICKS_W){1'b0}}, debounce_ticks}))
				? pressed[i] : stable_q[i];
		end
	end

	assign changed = !ctl.init && ((stable_next ^ stable_q) != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			stable_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				ct_q[i] <= '0;
			end
		end else if (ctl.load) begin
			prev_q <= pressed;
			stable_q <= stable_next;
			for (int i = 0; i < CHANNELS; i++) begin
				ct_q[i] <= ct_next[i];
			end
		end
	end
endmodule
`default_nettype wire

>>> hdl/multi_channel_debounce_reporter.sv
// Top level of the multi-channel switch debounce reporter.
//
// One tick request per millisecond carries the raw switch levels and an
// optional received byte. Requests enter an input register; once the report
// buffer is empty or sending its final report, the debounce lanes, heartbeat
// timer and status decode update in one pass and load a report buffer holding
// up to three pending reports (change event, heartbeat, status reply), sent in
// that order, one per cycle while report.ready is high, the final one marked
// with last. A request passes the input register and then the report buffer.
// Throughput: one request per cycle when a tick makes at most one report and
// report.ready stays high; otherwise the report output sets the pace.
// A new request is taken while the previous one's reports are still queued;
// the report buffer reloads in the cycle its final report is taken.
// Reset clears tick time, lanes and heartbeat time, and restores the register
// defaults (mask 0, debounce 25, heartbeat 1000). The first tick after reset
// only loads the lanes and sends one status report.
// When the receiver stalls, the report holds and requests back up into the
// input register, then tick.ready drops.
`default_nettype none
module multi_channel_debounce_reporter #(
	parameter int unsigned CHANNELS = mcdr_pkg::CHANNELS_DEF,
	localparam int unsigned CFG_W = (CHANNELS > mcdr_pkg::TICKS_W) ? CHANNELS
		: mcdr_pkg::TICKS_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire mcdr_pkg::cfg_index_t cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	mcdr_tick_if.sink                 tick,
	mcdr_report_if.source             report
);
	logic [CHANNELS-1:0] mask_q;
	logic [mcdr_pkg::TICKS_W-1:0] deb_q;
	logic [mcdr_pkg::TICKS_W-1:0] hb_q;

	logic s1_valid_q;
	logic [CHANNELS-1:0] raw_s1;
	logic rxv_s1;
	logic [mcdr_pkg::BYTE_W-1:0] rxb_s1;

	logic [mcdr_pkg::TIME_W-1:0] tick_time_q;
	logic [mcdr_pkg::TIME_W-1:0] hb_time_q;
	logic started_q;

	logic [2:0] pending_q;
	logic [CHANNELS-1:0] rep_stable_q;
	logic [mcdr_pkg::TIME_W-1:0] rep_time_q;

	logic [2:0] lowest;
	logic [2:0] pend_after;
	logic out_fire;
	logic proc;
	logic hb_hit;
	logic status_hit;
	logic [2:0] new_pend;
	logic [CHANNELS-1:0] pressed;
	logic [CHANNELS-1:0] stable_next;
	logic changed;
	logic [mcdr_pkg::TIME_W-1:0] hb_elapsed;
	mcdr_pkg::deb_ctl_t deb_ctl;
	mcdr_pkg::report_kind_t kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			deb_q <= mcdr_pkg::DEBOUNCE_TICKS_RST;
			hb_q <= mcdr_pkg::HEARTBEAT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mcdr_pkg::REG_ACTIVE_LOW_MASK: mask_q <= cfg_data[CHANNELS-1:0];
				mcdr_pkg::REG_DEBOUNCE_TICKS: deb_q <= cfg_data[mcdr_pkg::TICKS_W-1:0];
				mcdr_pkg::REG_HEARTBEAT_TICKS: hb_q <= cfg_data[mcdr_pkg::TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign lowest = pending_q & (~pending_q + 3'd1);
	assign out_fire = report.valid && report.ready;
	assign pend_after = out_fire ? (pending_q & ~lowest) : pending_q;
	assign proc = s1_valid_q && (pend_after == 3'b000);
	assign tick.ready = !s1_valid_q || proc;

	// hold the request until the report buffer can take its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (tick.ready) begin
			s1_valid_q <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			raw_s1 <= tick.raw_pins;
			rxv_s1 <= tick.rx_valid;
			rxb_s1 <= tick.rx_byte;
		end
	end

	assign pressed = raw_s1 ^ mask_q;
	assign deb_ctl.load = proc;
	assign deb_ctl.init = !started_q;

	mcdr_debounce #(
		.CHANNELS(CHANNELS)
	) u_debounce (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(deb_ctl),
		.pressed(pressed),
		.now(tick_time_q),
		.debounce_ticks(deb_q),
		.stable_next(stable_next),
		.changed(changed)
	);

	assign hb_elapsed = tick_time_q - hb_time_q;
	assign hb_hit = started_q
		&& (hb_elapsed >= {{(mcdr_pkg::TIME_W-mcdr_pkg::TICKS_W){1'b0}}, hb_q});
	assign status_hit = started_q && rxv_s1 && (rxb_s1 == mcdr_pkg::STATUS_BYTE);
	assign new_pend = started_q ? {status_hit, hb_hit, changed} : 3'b100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_time_q <= '0;
			hb_time_q <= '0;
			started_q <= 1'b0;
			pending_q <= '0;
		end else if (proc) begin
			tick_time_q <= tick_time_q + 1'b1;
			started_q <= 1'b1;
			pending_q <= new_pend;
			if (hb_hit) begin
				hb_time_q <= tick_time_q;
			end
		end else begin
			pending_q <= pend_after;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			rep_stable_q <= stable_next;
			rep_time_q <= tick_time_q;
		end
	end

	always_comb begin
		case (lowest)
			3'b001: kind = mcdr_pkg::KIND_EVENT;
			3'b010: kind = mcdr_pkg::KIND_HEARTBEAT;
			default: kind = mcdr_pkg::KIND_STATUS;
		endcase
	end

	assign report.valid = pending_q != 3'b000;
	assign report.report_kind = kind;
	assign report.stable_vector = rep_stable_q;
	assign report.timestamp = rep_time_q;
	assign report.any_pressed = rep_stable_q != '0;
	assign report.last = (pending_q & ~lowest) == 3'b000;
endmodule
`default_nettype wire
